[rtl/npsc_pkg.sv]
// npsc_pkg: shared types and constants of the nearest point on sampled curve block
// used by npsc_phase and nearest_point_on_sampled_curve_top; no dependencies
package npsc_pkg;

  // 2*pi in Q16 radians
  localparam int unsigned TWO_PI_Q16 = 411775;
  // floor(2^32 / TWO_PI_Q16) and its remainder, the turn step of one Q16 radian
  localparam int unsigned TURN_ONE_Q = 10430;
  localparam int unsigned TURN_ONE_R = 154046;
  // quarter turn in Q0.32
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_MOD_Q,
    ST_DIV_TURN,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npsc_state_e;

  typedef struct packed {
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic signed [15:0] query_z;
  } query_t;

  typedef struct packed {
    logic signed [15:0] nearest_x;
    logic signed [15:0] nearest_y;
    logic signed [15:0] nearest_z;
    logic [10:0]        nearest_index;
    logic               reverted;
  } result_t;

  // phase generator control
  typedef struct packed {
    logic clear;
    logic step;
  } phase_ctrl_t;

endpackage

[rtl/npsc_phase.sv]
// npsc_phase: incremental phase generator, one sample step per cycle while step is high
// keeps floor(curve_rate*i/N) mod 2*pi as an exact Q0.32 turn; uses npsc_pkg
module npsc_phase import npsc_pkg::*; #(
  parameter int unsigned NUM_SAMPLES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  phase_ctrl_t                          ctrl_i,
  input  logic [$clog2(NUM_SAMPLES+1)-1:0]     rem_step_i,
  input  logic [31:0]                          turn_step_i,
  input  logic [18:0]                          frac_step_i,
  output logic [31:0]                          turn_o
);

  localparam int unsigned NW = $clog2(NUM_SAMPLES + 1);

  logic [NW-1:0] rem_q, rem_d;
  logic [18:0]   frac_q, frac_d;
  logic [31:0]   turn_q, turn_d;

  logic [NW:0]   rem_sum;
  logic          carry;
  logic [20:0]   frac_sum, frac_one;
  logic          ge0, ge1;

  // remainder of rate*i/N carries one radian step into the phase
  always_comb begin
    rem_sum  = {1'b0, rem_q} + {1'b0, rem_step_i};
    carry    = rem_sum >= (NW+1)'(NUM_SAMPLES);
    rem_d    = carry ? NW'(rem_sum - (NW+1)'(NUM_SAMPLES)) : NW'(rem_sum);
    frac_sum = 21'(frac_q) + 21'(frac_step_i) + (carry ? 21'(TURN_ONE_R) : 21'd0);
    ge0      = frac_sum >= 21'(TWO_PI_Q16);
    frac_one = ge0 ? frac_sum - 21'(TWO_PI_Q16) : frac_sum;
    ge1      = frac_one >= 21'(TWO_PI_Q16);
    frac_d   = ge1 ? 19'(frac_one - 21'(TWO_PI_Q16)) : 19'(frac_one);
    turn_d   = turn_q + turn_step_i + (carry ? 32'(TURN_ONE_Q) : 32'd0)
             + 32'(ge0) + 32'(ge1);
  end

  // accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      frac_q <= '0;
      turn_q <= '0;
    end else if (ctrl_i.clear) begin
      rem_q  <= '0;
      frac_q <= '0;
      turn_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q  <= rem_d;
      frac_q <= frac_d;
      turn_q <= turn_d;
    end
  end

  assign turn_o = turn_q;

endmodule

[rtl/nearest_point_on_sampled_curve_top.sv]
// nearest_point_on_sampled_curve_top: nearest sample of a Lissajous curve to a query
// depends on npsc_pkg and npsc_phase
//
// Usage
//   Query channel: a transaction is accepted at a clock edge with start_i high and
//   busy_o low; query_i carries x, y, z in signed Q7.8 (z does not affect the choice).
//   Result channel: result_o is valid for exactly one cycle while result_valid_o is
//   high; the receiver cannot stall it. One result per query.
//   Config channel: curve_rate (unsigned Q8.16) is written at an edge with
//   cfg_valid_i and cfg_ready_o high; cfg_ready_o is high whenever busy_o is low.
// Sequence
//   A query first runs setup divisions in a shared subtract/compare unit (rate/N,
//   mod 2*pi, then the turn step), then one curve sample per cycle over
//   NUM_SAMPLES+1 samples through a four-stage lookup/square/compare pipeline,
//   then drain and finish. busy_o is high during all of that; a new query can
//   start on the cycle of the result strobe.
// Reset
//   curve_rate returns to 1.0 and the stored previous index to 0. The sine table
//   is a constant ROM and needs no fill.
module nearest_point_on_sampled_curve_top import npsc_pkg::*; #(
  parameter int unsigned NUM_SAMPLES      = 1024,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  query_t      query_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(NUM_SAMPLES + 1);
  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [4:0] RATE_LAST = 5'd23;
  localparam logic [4:0] MOD_LAST  = 5'd5;
  localparam logic [4:0] TURN_LAST = 5'd31;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  // per-entry step of the table angle, 2^32/depth as quotient and remainder
  localparam longint TABLE_DEPTH_L = longint'(SINE_TABLE_DEPTH);
  localparam longint TABLE_STEP_Q  = (64'sd1 <<< 32) / TABLE_DEPTH_L;
  localparam longint TABLE_STEP_R  = (64'sd1 <<< 32) % TABLE_DEPTH_L;

  typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

  // round(1280*sin(2*pi*u/2^32)), quarter wave series in Q30
  function automatic logic signed [15:0] sine_entry(longint u);
    longint r, th, t2, acc, s, v;
    longint quad;
    quad = (u >>> 30) & 64'sd3;
    r    = u & 64'sh3FFF_FFFF;
    if (quad[0]) r = ONE_Q30 - r;
    th  = (r * HALF_PI_Q30) >>> 30;
    t2  = (th * th) >>> 30;
    acc = ONE_Q30 - t2 / 110;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 72;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 42;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 20;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 6;
    s   = (th * acc) >>> 30;
    v   = (s * 1280 + 64'sd536870912) >>> 30;
    if (quad >= 2) v = -v;
    return 16'(v);
  endfunction

  // table angle floor(k*2^32/depth) kept as a running quotient and remainder
  function automatic rom_t build_rom();
    rom_t t;
    longint u, ur;
    u  = 0;
    ur = 0;
    for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t[k] = sine_entry(u);
      u    = u + TABLE_STEP_Q;
      ur   = ur + TABLE_STEP_R;
      if (ur >= TABLE_DEPTH_L) begin
        ur = ur - TABLE_DEPTH_L;
        u  = u + 64'sd1;
      end
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  npsc_state_e state_q, state_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [23:0]   rate_q;
  logic [NW-1:0] prev_q;
  query_t        query_q;

  // shared subtract/compare unit and its work registers
  logic [24:0]   work_q;
  logic [31:0]   quo_q;
  logic [NW-1:0] rem_step_q;
  logic [24:0]   sub_a, sub_b, sub_dif;
  logic          sub_ge;
  logic [2:0]    mod_sh;

  phase_ctrl_t   phase_ctrl;
  logic [31:0]   turn;

  // pipeline
  logic          v1_q, v2_q, v3_q;
  logic [NW-1:0] i1_q, i2_q, i3_q;
  logic [KW-1:0] kx_q, ky_q;
  logic signed [15:0] cx2_q, cy2_q, cx3_q, cy3_q;
  logic [33:0]   sqx_q, sqy_q;
  logic [34:0]   dist_sum;
  logic [34:0]   best_q;
  logic [NW-1:0] best_i_q;
  logic signed [15:0] bx_q, by_q, p0x_q, p0y_q, pnx_q, pny_q;

  logic [31:0]   ang_x, ang_y;
  logic [48:0]   prod_x, prod_y;
  logic signed [16:0] dx, dy;

  logic          rev;
  logic [NW-1:0] fin_i;
  logic [31:0]   fin_i_ext;
  logic          strobe_q;
  result_t       res_q;

  // operand select for the shared unit
  always_comb begin
    mod_sh = 3'(MOD_LAST) - cnt_q[2:0];
    sub_a  = '0;
    sub_b  = 25'(NUM_SAMPLES);
    case (state_q)
      ST_DIV_RATE: begin
        sub_a = {work_q[23:0], quo_q[23]};
        sub_b = 25'(NUM_SAMPLES);
      end
      ST_MOD_Q: begin
        sub_a = work_q;
        sub_b = 25'(TWO_PI_Q16) << mod_sh;
      end
      ST_DIV_TURN: begin
        sub_a = {work_q[23:0], 1'b0};
        sub_b = 25'(TWO_PI_Q16);
      end
      default: begin
        sub_a = '0;
      end
    endcase
    sub_ge  = sub_a >= sub_b;
    sub_dif = sub_a - sub_b;
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    idx_d            = idx_q;
    phase_ctrl.clear = 1'b0;
    phase_ctrl.step  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DIV_RATE;
          cnt_d   = '0;
        end
      end
      ST_DIV_RATE: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == RATE_LAST) begin
          state_d = ST_MOD_Q;
          cnt_d   = '0;
        end
      end
      ST_MOD_Q: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == MOD_LAST) begin
          state_d = ST_DIV_TURN;
          cnt_d   = '0;
        end
      end
      ST_DIV_TURN: begin
        cnt_d = cnt_q + 5'd1;
        phase_ctrl.clear = 1'b1;
        if (cnt_q == TURN_LAST) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        phase_ctrl.step = 1'b1;
        idx_d = idx_q + NW'(1);
        if (idx_q == NW'(NUM_SAMPLES)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (v3_q && i3_q == NW'(NUM_SAMPLES)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 24'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_data_i;
    end
  end

  // query capture and setup divisions: rate/N, then Q mod 2*pi, then Qm*2^32/(2*pi)
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          query_q <= query_i;
          work_q  <= '0;
          quo_q   <= {8'd0, rate_q};
        end
      end
      ST_DIV_RATE: begin
        work_q <= sub_ge ? sub_dif : sub_a;
        quo_q  <= {8'd0, quo_q[22:0], sub_ge};
        if (cnt_q == RATE_LAST) begin
          rem_step_q <= NW'(sub_ge ? sub_dif : sub_a);
          work_q     <= {1'b0, quo_q[22:0], sub_ge};
        end
      end
      ST_MOD_Q: begin
        if (sub_ge) work_q <= sub_dif;
      end
      ST_DIV_TURN: begin
        work_q <= sub_ge ? sub_dif : sub_a;
        quo_q  <= {quo_q[30:0], sub_ge};
      end
      default: begin
        work_q <= work_q;
      end
    endcase
  end

  npsc_phase #(
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (phase_ctrl),
    .rem_step_i  (rem_step_q),
    .turn_step_i (quo_q),
    .frac_step_i (work_q[18:0]),
    .turn_o      (turn)
  );

  // table addresses for cos(3a) and sin(2a), query differences and the distance sum
  always_comb begin
    ang_x    = turn + {turn[30:0], 1'b0} + QUARTER_TURN;
    ang_y    = {turn[30:0], 1'b0};
    prod_x   = 49'(ang_x) * 49'(SINE_TABLE_DEPTH);
    prod_y   = 49'(ang_y) * 49'(SINE_TABLE_DEPTH);
    dx       = {query_q.query_x[15], query_q.query_x} - {cx2_q[15], cx2_q};
    dy       = {query_q.query_y[15], query_q.query_y} - {cy2_q[15], cy2_q};
    dist_sum = 35'(sqx_q) + 35'(sqy_q);
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= state_q == ST_SCAN;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // address, lookup, square and compare stages
  always_ff @(posedge clk_i) begin
    i1_q  <= idx_q;
    kx_q  <= prod_x[32 +: KW];
    ky_q  <= prod_y[32 +: KW];
    i2_q  <= i1_q;
    cx2_q <= SineRom[kx_q];
    cy2_q <= SineRom[ky_q];
    i3_q  <= i2_q;
    cx3_q <= cx2_q;
    cy3_q <= cy2_q;
    sqx_q <= 34'(dx * dx);
    sqy_q <= 34'(dy * dy);
    if (v3_q) begin
      if (i3_q == '0 || dist_sum < best_q) begin
        best_q   <= dist_sum;
        best_i_q <= i3_q;
        bx_q     <= cx3_q;
        by_q     <= cy3_q;
      end
      if (i3_q == '0) begin
        p0x_q <= cx3_q;
        p0y_q <= cy3_q;
      end
      if (i3_q == NW'(NUM_SAMPLES)) begin
        pnx_q <= cx3_q;
        pny_q <= cy3_q;
      end
    end
  end

  // jump check: only index 0 against index N is a full span
  always_comb begin
    rev = (best_i_q == NW'(NUM_SAMPLES) && prev_q == '0) ||
          (best_i_q == '0 && prev_q == NW'(NUM_SAMPLES));
    fin_i     = rev ? prev_q : best_i_q;
    fin_i_ext = 32'(fin_i);
  end

  // result register and previous index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      prev_q   <= '0;
    end else begin
      strobe_q <= state_q == ST_FINISH;
      if (state_q == ST_FINISH) prev_q <= fin_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH) begin
      res_q.nearest_x     <= rev ? (prev_q == '0 ? p0x_q : pnx_q) : bx_q;
      res_q.nearest_y     <= rev ? (prev_q == '0 ? p0y_q : pny_q) : by_q;
      res_q.nearest_z     <= '0;
      res_q.nearest_index <= fin_i_ext[10:0];
      res_q.reverted      <= rev;
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign cfg_ready_o    = state_q == ST_IDLE;
  assign result_valid_o = strobe_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // the result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // a result is only shown once the block is free again
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted query makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("query accepted but block not busy");
`endif

endmodule

[tb/sv/npsc_checker.sv]
// npsc_checker: watches the query, result and config channels of the nearest point block
// predicts each result from its own curve model and compares; depends on npsc_pkg
`timescale 1ns / 1ps

module npsc_checker import npsc_pkg::*; #(
  parameter int unsigned NUM_SAMPLES      = 1024,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  query_t      query_i,
  input  logic        result_valid_i,
  input  result_t     result_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1 << 30;

  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [15:0] curve_x  [NUM_SAMPLES + 1];
  logic signed [15:0] curve_y  [NUM_SAMPLES + 1];
  logic [23:0]        curve_rate;
  int unsigned        last_index;
  result_t            nearest_queue [$];
  int                 fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = nearest_queue.size();

  // 5*sin in Q7.8 from a Q30 series on a quarter wave
  function automatic logic signed [15:0] sine_entry(int unsigned k);
    longint unsigned u;
    int unsigned     quad;
    longint          r, th, t2, acc, s, v;
    u    = (64'(k) << 32) / SINE_TABLE_DEPTH;
    quad = int'((u >> 30) & 3);
    r    = longint'(u & 64'h3FFF_FFFF);
    if (quad[0]) r = ONE_Q30 - r;
    th  = (r * HALF_PI_Q30) >>> 30;
    t2  = (th * th) >>> 30;
    acc = ONE_Q30 - t2 / 110;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 72;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 42;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 20;
    acc = ONE_Q30 - ((t2 * acc) >>> 30) / 6;
    s   = (th * acc) >>> 30;
    v   = (s * 1280 + (64'd1 << 29)) >>> 30;
    if (quad >= 2) v = -v;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] rom_at(logic [31:0] angle);
    longint unsigned k;
    k = (64'(angle) * SINE_TABLE_DEPTH) >> 32;
    if (k >= SINE_TABLE_DEPTH) k = SINE_TABLE_DEPTH - 1;
    return sine_rom[k];
  endfunction

  // sample the whole curve for the current rate
  task automatic sample_curve();
    longint unsigned rad, ph;
    logic [31:0]     turn;
    for (int unsigned i = 0; i <= NUM_SAMPLES; i++) begin
      rad  = (64'(curve_rate) * i) / NUM_SAMPLES;
      ph   = rad % TWO_PI_Q16;
      turn = 32'((ph << 32) / TWO_PI_Q16);
      curve_x[i] = rom_at(turn * 32'd3 + QUARTER_TURN);
      curve_y[i] = rom_at(turn * 32'd2);
    end
  endtask

  // nearest sample search with the jump check against the last index
  function automatic result_t predict_nearest(query_t q);
    result_t         r;
    longint          dx, dy;
    longint unsigned d, best;
    int unsigned     best_i, diff;
    best   = 0;
    best_i = 0;
    for (int unsigned i = 0; i <= NUM_SAMPLES; i++) begin
      dx = longint'(q.query_x) - longint'(curve_x[i]);
      dy = longint'(q.query_y) - longint'(curve_y[i]);
      d  = longint'(dx * dx) + longint'(dy * dy);
      if (i == 0 || d < best) begin
        best   = d;
        best_i = i;
      end
    end
    diff = best_i > last_index ? best_i - last_index : last_index - best_i;
    r.reverted = diff >= NUM_SAMPLES;
    if (r.reverted) best_i = last_index;
    last_index      = best_i;
    r.nearest_x     = curve_x[best_i];
    r.nearest_y     = curve_y[best_i];
    r.nearest_z     = '0;
    r.nearest_index = 11'(best_i);
    return r;
  endfunction

  initial begin
    for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++) sine_rom[k] = sine_entry(k);
    curve_rate = 24'd65536;
    last_index = 0;
    fail_count = 0;
    sample_curve();
  end

  // observe transactions on every channel
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      curve_rate = 24'd65536;
      last_index = 0;
      nearest_queue.delete();
      sample_curve();
    end else begin
      if (result_valid_i) begin
        if (nearest_queue.size() == 0) begin
          $error("result with no query outstanding: %h", result_i);
          fail_count++;
        end else begin
          exp_r = nearest_queue.pop_front();
          if (result_i.nearest_x !== exp_r.nearest_x) begin
            $error("nearest_x expected %0d actual %0d", exp_r.nearest_x, result_i.nearest_x);
            fail_count++;
          end
          if (result_i.nearest_y !== exp_r.nearest_y) begin
            $error("nearest_y expected %0d actual %0d", exp_r.nearest_y, result_i.nearest_y);
            fail_count++;
          end
          if (result_i.nearest_z !== exp_r.nearest_z) begin
            $error("nearest_z expected %0d actual %0d", exp_r.nearest_z, result_i.nearest_z);
            fail_count++;
          end
          if (result_i.nearest_index !== exp_r.nearest_index) begin
            $error("nearest_index expected %0d actual %0d",
                   exp_r.nearest_index, result_i.nearest_index);
            fail_count++;
          end
          if (result_i.reverted !== exp_r.reverted) begin
            $error("reverted expected %0d actual %0d", exp_r.reverted, result_i.reverted);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_i) nearest_queue.push_back(predict_nearest(query_i));
      if (cfg_valid_i && cfg_ready_i) begin
        curve_rate = cfg_data_i;
        sample_curve();
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
// tb_top: stimulus and verdict for nearest_point_on_sampled_curve_top
// depends on npsc_pkg, the block and npsc_checker
`timescale 1ns / 1ps

module tb_top;
  import npsc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  query_t      query_i;
  logic        result_valid_o;
  result_t     result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i;
  int          fail_count;
  int          pending;

  nearest_point_on_sampled_curve_top u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .query_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  npsc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .query_i, .result_valid_i(result_valid_o),
    .result_i(result_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  initial begin
    #40ms;
    $display("tb_top failed");
    $finish;
  end

  int burst_left;

  // drop start_i, wait for all results, then keep clocking before returning
  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // write curve_rate while idle
  task automatic write_rate(logic [23:0] rate);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one query transaction, bursts of back-to-back starts with random gaps
  task automatic send_query(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    start_i <= 1'b1;
    query_i <= '{query_x: x, query_y: y, query_z: z};
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      default: return 16'($signed($urandom_range(0, 3000)) - 1500);
    endcase
  endfunction

  logic [23:0] rates [6] = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd411775, 24'd1, 24'd205887};

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    query_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    burst_left  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes at the reset rate, z ignored, ties at zero rate, then the largest rate and 2*pi
    send_query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_query(-16'sh8000, -16'sh8000, -16'sh8000);
    send_query(16'sh7FFF, -16'sh8000, 16'sh0000);
    send_query(16'sd0, 16'sd0, 16'sh7FFF);
    send_query(16'sd0, 16'sd0, -16'sh8000);
    send_query(16'sd1280, 16'sd0, 16'sd5);
    send_query(-16'sd1280, 16'sd1280, 16'sd0);
    write_rate(24'd0);
    send_query(16'sd100, 16'sd100, 16'sd0);
    send_query(-16'sh8000, 16'sh7FFF, 16'sd0);
    write_rate(24'hFFFFFF);
    send_query(16'sd1280, 16'sd0, 16'sd0);
    send_query(-16'sd1280, -16'sd1280, 16'sd0);
    write_rate(24'd411775);
    send_query(16'sd1280, 16'sd0, 16'sd0);
    send_query(16'sd0, 16'sd1280, 16'sd0);

    // random phases, each at its own rate
    for (int ph = 0; ph < 8; ph++) begin
      write_rate(ph < 6 ? rates[ph] : 24'($urandom));
      repeat (70) send_query(rand_coord(), rand_coord(), 16'($urandom));
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
